[hdl/cit_pkg.sv]
// Shared constants, types and helpers for the circle intersection and tangent block.
`default_nettype none
package cit_pkg;

   localparam logic OP_INTERSECT = 1'b0;
   localparam logic OP_TANGENT   = 1'b1;

   localparam int SQRT_STEPS = 64;
   localparam int DIV_STEPS  = 42;
   localparam int DIV_LAT    = DIV_STEPS + 1;
   localparam int DVD_W      = 98;
   localparam int DVS_W      = 67;
   localparam int QUO_W      = 41;
   localparam int DEN_W      = 66;

   typedef struct packed {
      logic               found;
      logic               onc;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic               sdx;
      logic               sdy;
      logic               pneg;
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic [63:0]        p;
      logic [DEN_W-1:0]   den;
   } ctx_type;

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if (v > 44'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -44'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [41:0] apply_sign(input logic [QUO_W-1:0] q,
                                                     input logic neg);
      logic signed [41:0] m;
      m = $signed({1'b0, q});
      return neg ? -m : m;
   endfunction

endpackage
`default_nettype wire

[hdl/cit_if.sv]
// Request and response channel interfaces of the circle intersection and tangent block.
`default_nettype none
interface cit_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] first_center_x;
   logic signed [31:0] first_center_y;
   logic [30:0]        first_radius;
   logic signed [31:0] second_center_x;
   logic signed [31:0] second_center_y;
   logic [30:0]        second_radius;

   modport source (output valid, opcode, first_center_x, first_center_y, first_radius,
                   second_center_x, second_center_y, second_radius, input ready);
   modport sink (input valid, opcode, first_center_x, first_center_y, first_radius,
                 second_center_x, second_center_y, second_radius, output ready);
endinterface

interface cit_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [31:0] point_a_x;
   logic signed [31:0] point_a_y;
   logic signed [31:0] point_b_x;
   logic signed [31:0] point_b_y;

   modport source (output valid, found, point_a_x, point_a_y, point_b_x, point_b_y,
                   input ready);
   modport sink (input valid, found, point_a_x, point_a_y, point_b_x, point_b_y,
                 output ready);
endinterface
`default_nettype wire

[hdl/circle_intersection_and_tangent.sv]
// Top level of the circle intersection and tangent pipeline.
// Each request transaction carries a first circle and either a second circle (intersection)
// or an outside point (tangent points); each yields exactly one response transaction with a
// found flag and two Q16.16 points, in order. The pipeline takes one transaction per clock
// unless stalled and has 7 setup and multiply stages, one root argument stage, one stage
// per bit of a 64-step square root, 2 numerator multiply stages, a 43-stage divider (an
// input stage, then one quotient bit per stage) and 2 output stages. While a response
// waits on rsp_port.ready the whole pipeline holds and req_port.ready is low.
`default_nettype none
module circle_intersection_and_tangent (
   input wire        clock,
   input wire        reset,
   cit_req_if.sink   req_port,
   cit_rsp_if.source rsp_port
);
   import cit_pkg::*;

   logic adv;

   // stage A
   logic               a_v_ff, a_op_ff;
   logic signed [31:0] a_cx_ff, a_cy_ff, a_px_ff, a_py_ff;
   logic [30:0]        a_r0_ff, a_r1_ff;
   // stage B
   logic               b_v_ff, b_op_ff, b_sdx_ff, b_sdy_ff;
   logic signed [31:0] b_cx_ff, b_cy_ff, b_px_ff, b_py_ff;
   logic [30:0]        b_r0_ff, b_r1_ff, b_rd_ff;
   logic [31:0]        b_adx_ff, b_ady_ff, b_rs_ff;
   logic signed [32:0] b_dx_in, b_dy_in;
   // stage C
   logic               c_v_ff, c_op_ff, c_sdx_ff, c_sdy_ff;
   logic signed [31:0] c_cx_ff, c_cy_ff, c_px_ff, c_py_ff;
   logic [31:0]        c_adx_ff, c_ady_ff;
   logic [63:0]        c_dx2_ff, c_dy2_ff, c_rs2_ff;
   logic [61:0]        c_r0sq_ff, c_r1sq_ff, c_rd2_ff;
   // stage D
   logic               d_v_ff, d_op_ff, d_sdx_ff, d_sdy_ff;
   logic signed [31:0] d_cx_ff, d_cy_ff, d_px_ff, d_py_ff;
   logic [31:0]        d_adx_ff, d_ady_ff;
   logic [63:0]        d_rs2_ff;
   logic [61:0]        d_r0sq_ff, d_r1sq_ff, d_rd2_ff;
   logic [64:0]        d_d2_ff;
   logic [65:0]        d_sum_ff;
   // stage E
   logic               e_v_ff, e_op_ff;
   ctx_type            e_ctx_ff, e_ctx_in;
   logic [63:0]        e_ma_ff, e_ma_in;
   logic [64:0]        e_mb_ff, e_mb_in;
   logic               e_nneg;
   logic [65:0]        e_ndiff;
   // stage F
   logic               f_v_ff, f_op_ff;
   ctx_type            f_ctx_ff;
   logic [64:0]        f_p00_ff, f_p01_ff, f_p10_ff, f_p11_ff;
   logic [63:0]        f_nll_ff, f_nlh_ff, f_nhh_ff;
   // stage G
   logic               g_v_ff, g_op_ff;
   ctx_type            g_ctx_ff;
   logic [127:0]       g_q_ff, g_nsq_ff;
   // square root pipeline
   logic               sq_v_ff    [0:SQRT_STEPS];
   ctx_type            sq_ctx_ff  [0:SQRT_STEPS];
   logic [127:0]       sq_x_ff    [0:SQRT_STEPS];
   logic [65:0]        sq_rem_ff  [0:SQRT_STEPS];
   logic [63:0]        sq_root_ff [0:SQRT_STEPS];
   // numerator stages
   logic               m1_v_ff;
   ctx_type            m1_ctx_ff;
   logic [63:0]        m1_xpl_ff, m1_xph_ff, m1_ypl_ff, m1_yph_ff;
   logic [63:0]        m1_xsl_ff, m1_xsh_ff, m1_ysl_ff, m1_ysh_ff;
   logic [DVD_W-1:0]   m2_nfx_ff, m2_nfy_ff, m2_nmx_ff, m2_nmy_ff;
   logic [DVS_W-1:0]   m2_dvs_ff;
   logic               dv_v_ff   [0:DIV_LAT];
   ctx_type            dv_ctx_ff [0:DIV_LAT];
   logic [QUO_W-1:0]   q_fx, q_fy, q_mx, q_my;
   // output stages
   logic               o1_v_ff;
   ctx_type            o1_ctx_ff;
   logic signed [42:0] o1_fx_ff, o1_fy_ff;
   logic signed [41:0] o1_mx_ff, o1_my_ff;
   logic signed [43:0] o2_ax, o2_ay, o2_bx, o2_by;
   logic               out_v_ff, out_found_ff;
   logic signed [31:0] out_ax_ff, out_ay_ff, out_bx_ff, out_by_ff;

   assign adv            = !out_v_ff || rsp_port.ready;
   assign req_port.ready = adv;

   // stage A: capture transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_port.valid;
      end
      if (adv) begin
         a_op_ff <= req_port.opcode;
         a_cx_ff <= req_port.first_center_x;
         a_cy_ff <= req_port.first_center_y;
         a_r0_ff <= req_port.first_radius;
         a_px_ff <= req_port.second_center_x;
         a_py_ff <= req_port.second_center_y;
         a_r1_ff <= req_port.second_radius;
      end
   end

   // stage B: differences
   always_comb begin
      b_dx_in = {a_px_ff[31], a_px_ff} - {a_cx_ff[31], a_cx_ff};
      b_dy_in = {a_py_ff[31], a_py_ff} - {a_cy_ff[31], a_cy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
      if (adv) begin
         b_op_ff  <= a_op_ff;
         b_cx_ff  <= a_cx_ff;
         b_cy_ff  <= a_cy_ff;
         b_px_ff  <= a_px_ff;
         b_py_ff  <= a_py_ff;
         b_r0_ff  <= a_r0_ff;
         b_r1_ff  <= a_r1_ff;
         b_sdx_ff <= b_dx_in[32];
         b_sdy_ff <= b_dy_in[32];
         b_adx_ff <= b_dx_in[32] ? 32'(-b_dx_in) : b_dx_in[31:0];
         b_ady_ff <= b_dy_in[32] ? 32'(-b_dy_in) : b_dy_in[31:0];
         b_rs_ff  <= {1'b0, a_r0_ff} + {1'b0, a_r1_ff};
         b_rd_ff  <= (a_r0_ff > a_r1_ff) ? a_r0_ff - a_r1_ff : a_r1_ff - a_r0_ff;
      end
   end

   // stage C: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
      if (adv) begin
         c_op_ff   <= b_op_ff;
         c_cx_ff   <= b_cx_ff;
         c_cy_ff   <= b_cy_ff;
         c_px_ff   <= b_px_ff;
         c_py_ff   <= b_py_ff;
         c_sdx_ff  <= b_sdx_ff;
         c_sdy_ff  <= b_sdy_ff;
         c_adx_ff  <= b_adx_ff;
         c_ady_ff  <= b_ady_ff;
         c_dx2_ff  <= b_adx_ff * b_adx_ff;
         c_dy2_ff  <= b_ady_ff * b_ady_ff;
         c_rs2_ff  <= b_rs_ff * b_rs_ff;
         c_r0sq_ff <= b_r0_ff * b_r0_ff;
         c_r1sq_ff <= b_r1_ff * b_r1_ff;
         c_rd2_ff  <= b_rd_ff * b_rd_ff;
      end
   end

   // stage D: distance squared
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= c_v_ff;
      end
      if (adv) begin
         d_op_ff   <= c_op_ff;
         d_cx_ff   <= c_cx_ff;
         d_cy_ff   <= c_cy_ff;
         d_px_ff   <= c_px_ff;
         d_py_ff   <= c_py_ff;
         d_sdx_ff  <= c_sdx_ff;
         d_sdy_ff  <= c_sdy_ff;
         d_adx_ff  <= c_adx_ff;
         d_ady_ff  <= c_ady_ff;
         d_rs2_ff  <= c_rs2_ff;
         d_r0sq_ff <= c_r0sq_ff;
         d_r1sq_ff <= c_r1sq_ff;
         d_rd2_ff  <= c_rd2_ff;
         d_d2_ff   <= {1'b0, c_dx2_ff} + {1'b0, c_dy2_ff};
         d_sum_ff  <= {2'b0, c_dx2_ff} + {2'b0, c_dy2_ff} + {4'b0, c_r0sq_ff};
      end
   end

   // stage E: existence tests and operand selection
   always_comb begin
      e_nneg  = {4'b0, d_r1sq_ff} > d_sum_ff;
      e_ndiff = e_nneg ? {4'b0, d_r1sq_ff} - d_sum_ff : d_sum_ff - {4'b0, d_r1sq_ff};
      e_ctx_in.cx  = d_cx_ff;
      e_ctx_in.cy  = d_cy_ff;
      e_ctx_in.px  = d_px_ff;
      e_ctx_in.py  = d_py_ff;
      e_ctx_in.sdx = d_sdx_ff;
      e_ctx_in.sdy = d_sdy_ff;
      e_ctx_in.adx = d_adx_ff;
      e_ctx_in.ady = d_ady_ff;
      unique case (d_op_ff)
         OP_INTERSECT: begin
            e_ctx_in.found = !(d_d2_ff == '0 || d_d2_ff > {1'b0, d_rs2_ff}
                               || d_d2_ff < {3'b0, d_rd2_ff});
            e_ctx_in.onc   = 1'b0;
            e_ctx_in.pneg  = e_nneg;
            e_ctx_in.p     = e_ndiff[63:0];
            e_ctx_in.den   = {d_d2_ff, 1'b0};
            e_ma_in        = {d_r0sq_ff, 2'b00};
            e_mb_in        = {1'b0, d_d2_ff[63:0]};
         end
         OP_TANGENT: begin
            e_ctx_in.found = d_d2_ff >= {3'b0, d_r0sq_ff};
            e_ctx_in.onc   = d_d2_ff == {3'b0, d_r0sq_ff};
            e_ctx_in.pneg  = 1'b0;
            e_ctx_in.p     = {2'b0, d_r0sq_ff};
            e_ctx_in.den   = {1'b0, d_d2_ff};
            e_ma_in        = {2'b0, d_r0sq_ff};
            e_mb_in        = d_d2_ff - {3'b0, d_r0sq_ff};
         end
         default: begin
            e_ctx_in.found = 1'b0;
            e_ctx_in.onc   = 1'b0;
            e_ctx_in.pneg  = 1'b0;
            e_ctx_in.p     = '0;
            e_ctx_in.den   = '0;
            e_ma_in        = '0;
            e_mb_in        = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= d_v_ff;
      end
      if (adv) begin
         e_op_ff  <= d_op_ff;
         e_ctx_ff <= e_ctx_in;
         e_ma_ff  <= e_ma_in;
         e_mb_ff  <= e_mb_in;
      end
   end

   // stage F: partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= e_v_ff;
      end
      if (adv) begin
         f_op_ff  <= e_op_ff;
         f_ctx_ff <= e_ctx_ff;
         f_p00_ff <= e_ma_ff[31:0] * e_mb_ff[32:0];
         f_p01_ff <= e_ma_ff[31:0] * {1'b0, e_mb_ff[64:33]};
         f_p10_ff <= e_ma_ff[63:32] * e_mb_ff[32:0];
         f_p11_ff <= e_ma_ff[63:32] * {1'b0, e_mb_ff[64:33]};
         f_nll_ff <= e_ctx_ff.p[31:0] * e_ctx_ff.p[31:0];
         f_nlh_ff <= e_ctx_ff.p[31:0] * e_ctx_ff.p[63:32];
         f_nhh_ff <= e_ctx_ff.p[63:32] * e_ctx_ff.p[63:32];
      end
   end

   // stage G: sum partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= f_v_ff;
      end
      if (adv) begin
         g_op_ff  <= f_op_ff;
         g_ctx_ff <= f_ctx_ff;
         g_q_ff   <= 128'(f_p00_ff) + (128'(f_p01_ff) << 33) + (128'(f_p10_ff) << 32)
                     + (128'(f_p11_ff) << 65);
         g_nsq_ff <= 128'(f_nll_ff) + (128'(f_nlh_ff) << 33) + (128'(f_nhh_ff) << 64);
      end
   end

   // stage H: square root argument
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= g_v_ff;
      end
      if (adv) begin
         sq_ctx_ff[0]  <= g_ctx_ff;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         if (g_op_ff == OP_TANGENT) begin
            sq_x_ff[0] <= g_q_ff;
         end else begin
            sq_x_ff[0] <= (g_q_ff > g_nsq_ff) ? g_q_ff - g_nsq_ff : '0;
         end
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int BIT = SQRT_STEPS - 1 - k;
      logic [67:0] trial;
      logic [67:0] subtr;
      logic        take;

      always_comb begin
         trial = {sq_rem_ff[k], sq_x_ff[k][2*BIT+1 -: 2]};
         subtr = {2'b00, sq_root_ff[k], 2'b01};
         take  = trial >= subtr;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         if (adv) begin
            sq_ctx_ff[k+1]  <= sq_ctx_ff[k];
            sq_x_ff[k+1]    <= sq_x_ff[k];
            sq_rem_ff[k+1]  <= take ? 66'(trial - subtr) : trial[65:0];
            sq_root_ff[k+1] <= {sq_root_ff[k][62:0], take};
         end
      end
   end

   // numerator partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= sq_v_ff[SQRT_STEPS];
      end
      if (adv) begin
         m1_ctx_ff <= sq_ctx_ff[SQRT_STEPS];
         m1_xpl_ff <= sq_ctx_ff[SQRT_STEPS].adx * sq_ctx_ff[SQRT_STEPS].p[31:0];
         m1_xph_ff <= sq_ctx_ff[SQRT_STEPS].adx * sq_ctx_ff[SQRT_STEPS].p[63:32];
         m1_ypl_ff <= sq_ctx_ff[SQRT_STEPS].ady * sq_ctx_ff[SQRT_STEPS].p[31:0];
         m1_yph_ff <= sq_ctx_ff[SQRT_STEPS].ady * sq_ctx_ff[SQRT_STEPS].p[63:32];
         m1_xsl_ff <= sq_ctx_ff[SQRT_STEPS].adx * sq_root_ff[SQRT_STEPS][31:0];
         m1_xsh_ff <= sq_ctx_ff[SQRT_STEPS].adx * sq_root_ff[SQRT_STEPS][63:32];
         m1_ysl_ff <= sq_ctx_ff[SQRT_STEPS].ady * sq_root_ff[SQRT_STEPS][31:0];
         m1_ysh_ff <= sq_ctx_ff[SQRT_STEPS].ady * sq_root_ff[SQRT_STEPS][63:32];
      end
   end

   // rounded dividends: 2*num + den over 2*den
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= m1_v_ff;
      end
      if (adv) begin
         dv_ctx_ff[0] <= m1_ctx_ff;
         m2_nfx_ff <= ((DVD_W'(m1_xpl_ff) + (DVD_W'(m1_xph_ff) << 32)) << 1)
                      + DVD_W'(m1_ctx_ff.den);
         m2_nfy_ff <= ((DVD_W'(m1_ypl_ff) + (DVD_W'(m1_yph_ff) << 32)) << 1)
                      + DVD_W'(m1_ctx_ff.den);
         m2_nmx_ff <= ((DVD_W'(m1_ysl_ff) + (DVD_W'(m1_ysh_ff) << 32)) << 1)
                      + DVD_W'(m1_ctx_ff.den);
         m2_nmy_ff <= ((DVD_W'(m1_xsl_ff) + (DVD_W'(m1_xsh_ff) << 32)) << 1)
                      + DVD_W'(m1_ctx_ff.den);
         m2_dvs_ff <= {m1_ctx_ff.den, 1'b0};
      end
   end

   cit_div u_div_fx (.clock(clock), .enable(adv), .dividend(m2_nfx_ff),
                     .divisor(m2_dvs_ff), .quotient(q_fx));
   cit_div u_div_fy (.clock(clock), .enable(adv), .dividend(m2_nfy_ff),
                     .divisor(m2_dvs_ff), .quotient(q_fy));
   cit_div u_div_mx (.clock(clock), .enable(adv), .dividend(m2_nmx_ff),
                     .divisor(m2_dvs_ff), .quotient(q_mx));
   cit_div u_div_my (.clock(clock), .enable(adv), .dividend(m2_nmy_ff),
                     .divisor(m2_dvs_ff), .quotient(q_my));

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_dvctx
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         if (adv) begin
            dv_ctx_ff[k+1] <= dv_ctx_ff[k];
         end
      end
   end

   // apply signs, form foot point
   always_ff @(posedge clock) begin
      if (reset) begin
         o1_v_ff <= 1'b0;
      end else if (adv) begin
         o1_v_ff <= dv_v_ff[DIV_LAT];
      end
      if (adv) begin
         o1_ctx_ff <= dv_ctx_ff[DIV_LAT];
         o1_fx_ff  <= 43'(dv_ctx_ff[DIV_LAT].cx)
                      + 43'(apply_sign(q_fx, dv_ctx_ff[DIV_LAT].sdx ^ dv_ctx_ff[DIV_LAT].pneg));
         o1_fy_ff  <= 43'(dv_ctx_ff[DIV_LAT].cy)
                      + 43'(apply_sign(q_fy, dv_ctx_ff[DIV_LAT].sdy ^ dv_ctx_ff[DIV_LAT].pneg));
         o1_mx_ff  <= apply_sign(q_mx, !dv_ctx_ff[DIV_LAT].sdy);
         o1_my_ff  <= apply_sign(q_my, dv_ctx_ff[DIV_LAT].sdx);
      end
   end

   always_comb begin
      o2_ax = 44'(o1_fx_ff) + 44'(o1_mx_ff);
      o2_ay = 44'(o1_fy_ff) + 44'(o1_my_ff);
      o2_bx = 44'(o1_fx_ff) - 44'(o1_mx_ff);
      o2_by = 44'(o1_fy_ff) - 44'(o1_my_ff);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= o1_v_ff;
      end
      if (adv) begin
         out_found_ff <= o1_ctx_ff.found;
         if (!o1_ctx_ff.found) begin
            out_ax_ff <= '0;
            out_ay_ff <= '0;
            out_bx_ff <= '0;
            out_by_ff <= '0;
         end else if (o1_ctx_ff.onc) begin
            out_ax_ff <= o1_ctx_ff.px;
            out_ay_ff <= o1_ctx_ff.py;
            out_bx_ff <= o1_ctx_ff.px;
            out_by_ff <= o1_ctx_ff.py;
         end else begin
            out_ax_ff <= sat32(o2_ax);
            out_ay_ff <= sat32(o2_ay);
            out_bx_ff <= sat32(o2_bx);
            out_by_ff <= sat32(o2_by);
         end
      end
   end

   assign rsp_port.valid     = out_v_ff;
   assign rsp_port.found     = out_found_ff;
   assign rsp_port.point_a_x = out_ax_ff;
   assign rsp_port.point_a_y = out_ay_ff;
   assign rsp_port.point_b_x = out_bx_ff;
   assign rsp_port.point_b_y = out_by_ff;

endmodule
`default_nettype wire

[hdl/cit_div.sv]
// Pipelined restoring divider with saturating clamp, one quotient bit per stage.
`default_nettype none
module cit_div (
   input  wire                          clock,
   input  wire                          enable,
   input  wire  [cit_pkg::DVD_W-1:0]    dividend,
   input  wire  [cit_pkg::DVS_W-1:0]    divisor,
   output logic [cit_pkg::QUO_W-1:0]    quotient
);
   import cit_pkg::*;

   localparam logic [DIV_STEPS-1:0] SAT_Q = DIV_STEPS'(1) << (QUO_W - 1);

   logic                 ovf_ff [0:DIV_STEPS];
   logic [DVS_W-1:0]     dvs_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [0:DIV_STEPS];
   logic [DVS_W-1:0]     rem_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (enable) begin
         ovf_ff[0] <= (DVS_W + DIV_STEPS)'(dividend) >= {divisor, DIV_STEPS'(0)};
         dvs_ff[0] <= divisor;
         low_ff[0] <= dividend[DIV_STEPS-1:0];
         rem_ff[0] <= DVS_W'(dividend[DVD_W-1:DIV_STEPS]);
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - k;
      logic [DVS_W:0] trial;
      logic [DVS_W:0] dvs_ext;
      logic           take;

      always_comb begin
         trial   = {rem_ff[k], low_ff[k][BIT]};
         dvs_ext = {1'b0, dvs_ff[k]};
         take    = trial >= dvs_ext;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            ovf_ff[k+1] <= ovf_ff[k];
            dvs_ff[k+1] <= dvs_ff[k];
            low_ff[k+1] <= low_ff[k];
            rem_ff[k+1] <= take ? DVS_W'(trial - dvs_ext) : trial[DVS_W-1:0];
            quo_ff[k+1] <= {quo_ff[k][DIV_STEPS-2:0], take};
         end
      end
   end

   always_comb begin
      if (ovf_ff[DIV_STEPS] || quo_ff[DIV_STEPS] > SAT_Q) begin
         quotient = SAT_Q[QUO_W-1:0];
      end else begin
         quotient = quo_ff[DIV_STEPS][QUO_W-1:0];
      end
   end

endmodule
`default_nettype wire

[bench/circle_intersection_and_tangent_tb.sv]
// Testbench for the circle intersection and tangent pipeline with an internal predictor.
`timescale 1ns / 100ps
`default_nettype none
module circle_intersection_and_tangent_tb;
   import cit_pkg::*;

   typedef logic [127:0] u128_type;

   typedef struct {
      logic               opcode;
      logic signed [31:0] c0x;
      logic signed [31:0] c0y;
      logic [30:0]        r0;
      logic signed [31:0] c1x;
      logic signed [31:0] c1y;
      logic [30:0]        r1;
   } shape_type;

   typedef struct {
      logic               found;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
   } points_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fails = 0;
   bit   calm  = 1'b0;
   int   rsp_stall = 0;
   points_type expected_points[$];

   cit_req_if req_bus();
   cit_rsp_if rsp_bus();

   circle_intersection_and_tangent i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint unsigned mag(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round |v|*m/den to nearest, ties away from zero, capped at 2^40
   function automatic longint rounded_quot(input longint v, input bit neg,
                                           input longint unsigned m, input u128_type den);
      u128_type num, q;
      longint   r;
      num = u128_type'(mag(v)) * u128_type'(m);
      q = (den == 0) ? u128_type'(0) : ((num << 1) + den) / (den << 1);
      r = (q > (u128_type'(1) << 40)) ? (64'sd1 <<< 40) : longint'(q[63:0]);
      return ((v < 0) != neg) ? -r : r;
   endfunction

   function automatic longint unsigned floor_sqrt(input u128_type x);
      longint unsigned res, t;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (u128_type'(t) * u128_type'(t) <= x) res = t;
      end
      return res;
   endfunction

   function automatic points_type place_points(input longint cx, input longint cy,
                                               input longint dx, input longint dy,
                                               input bit pneg, input longint unsigned p,
                                               input longint unsigned s,
                                               input u128_type den);
      points_type e;
      longint     fx, fy, mx, my;
      fx = cx + rounded_quot(dx, pneg, p, den);
      fy = cy + rounded_quot(dy, pneg, p, den);
      mx = rounded_quot(dy, 1'b1, s, den);
      my = rounded_quot(dx, 1'b0, s, den);
      e.found = 1'b1;
      e.ax = clamp32(fx + mx);
      e.ay = clamp32(fy + my);
      e.bx = clamp32(fx - mx);
      e.by = clamp32(fy - my);
      return e;
   endfunction

   function automatic points_type predict_points(input shape_type sh);
      points_type      e;
      longint          cx, cy, px, py, dx, dy;
      longint unsigned r0, r1, rs, rd, n;
      u128_type        d2, r0sq, r1sq, sum, q, nsq;
      bit              nneg;
      e = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      cx = sh.c0x;
      cy = sh.c0y;
      px = sh.c1x;
      py = sh.c1y;
      r0 = sh.r0;
      r1 = sh.r1;
      dx = px - cx;
      dy = py - cy;
      d2 = u128_type'(mag(dx)) * u128_type'(mag(dx))
           + u128_type'(mag(dy)) * u128_type'(mag(dy));
      r0sq = u128_type'(r0) * u128_type'(r0);
      if (sh.opcode == OP_INTERSECT) begin
         rs = r0 + r1;
         rd = (r0 > r1) ? r0 - r1 : r1 - r0;
         if (d2 == 0) return e;
         if (d2 > u128_type'(rs) * u128_type'(rs)) return e;
         if (d2 < u128_type'(rd) * u128_type'(rd)) return e;
         sum = r0sq + d2;
         r1sq = u128_type'(r1) * u128_type'(r1);
         nneg = r1sq > sum;
         n = nneg ? 64'(r1sq - sum) : 64'(sum - r1sq);
         q = (u128_type'(r0 * r0) * u128_type'(d2[63:0])) << 2;
         nsq = u128_type'(n) * u128_type'(n);
         q = (q > nsq) ? q - nsq : u128_type'(0);
         return place_points(cx, cy, dx, dy, nneg, n, floor_sqrt(q), d2 << 1);
      end
      if (d2 < r0sq) return e;
      if (d2 == r0sq) begin
         e = '{1'b1, sh.c1x, sh.c1y, sh.c1x, sh.c1y};
         return e;
      end
      return place_points(cx, cy, dx, dy, 1'b0, r0 * r0,
                          floor_sqrt(r0sq * (d2 - r0sq)), d2);
   endfunction

   task automatic send_shape(input shape_type sh);
      if (!calm && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.opcode          <= sh.opcode;
      req_bus.first_center_x  <= sh.c0x;
      req_bus.first_center_y  <= sh.c0y;
      req_bus.first_radius    <= sh.r0;
      req_bus.second_center_x <= sh.c1x;
      req_bus.second_center_y <= sh.c1y;
      req_bus.second_radius   <= sh.r1;
      do @(posedge clock); while (!req_bus.ready);
      expected_points.push_back(predict_points(sh));
   endtask

   task automatic send_fields(input logic op, input int c0x, input int c0y, input int r0,
                              input int c1x, input int c1y, input int r1);
      shape_type sh;
      sh = '{op, c0x, c0y, r0[30:0], c1x, c1y, r1[30:0]};
      send_shape(sh);
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      go_idle();
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // random shape at a random scale so that most pairs overlap and reach the root path
   function automatic shape_type random_shape(input logic op);
      shape_type sh;
      int        w;
      w = $urandom_range(1, 31);
      sh.opcode = op;
      sh.c0x = $urandom;
      sh.c0y = $urandom;
      if ($urandom_range(0, 4) == 0) begin
         sh.c1x = $urandom;
         sh.c1y = $urandom;
         sh.r0 = 31'($urandom);
         sh.r1 = 31'($urandom);
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            sh.c0x = $signed($urandom) >>> 8;
            sh.c0y = $signed($urandom) >>> 8;
         end
         sh.c1x = sh.c0x + ($signed($urandom) >>> (32 - w));
         sh.c1y = sh.c0y + ($signed($urandom) >>> (32 - w));
         sh.r0 = 31'($urandom >> (op == OP_TANGENT ? 33 - w : 32 - w));
         sh.r1 = 31'($urandom >> (32 - w));
      end
      return sh;
   endfunction

   task automatic test_directed();
      int one;
      one = 32'h0001_0000;
      send_fields(OP_INTERSECT, 0, 0, 0, 0, 0, 0);
      send_fields(OP_INTERSECT, 5 * one, 5 * one, 3 * one, 5 * one, 5 * one, 3 * one);
      send_fields(OP_INTERSECT, 0, 0, one, 10 * one, 0, one);
      send_fields(OP_INTERSECT, 0, 0, 10 * one, one, 0, one);
      send_fields(OP_INTERSECT, 0, 0, one, one, 0, 10 * one);
      send_fields(OP_INTERSECT, 0, 0, one, 2 * one, 0, one);
      send_fields(OP_INTERSECT, 0, 0, 3 * one, 0, one, 2 * one);
      send_fields(OP_INTERSECT, 0, 0, 5 * one, 6 * one, 0, 5 * one);
      send_fields(OP_INTERSECT, -3 * one, one, 2 * one, one, -2 * one, 4 * one);
      send_fields(OP_INTERSECT, 32'sh80000000, 32'sh80000000, 32'h7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'h7fffffff);
      send_fields(OP_INTERSECT, 32'sh7fffffff, 0, 32'h7fffffff,
                  32'sh80000000, 0, 32'h7fffffff);
      send_fields(OP_INTERSECT, 32'sh7fffff00, 32'sh7fffff00, 32'h7fffffff,
                  32'sh7fffff00, 32'sh7ffffe00, 32'h7fffffff);
      send_fields(OP_INTERSECT, 0, 0, 1, 1, 0, 1);
      send_fields(OP_TANGENT, 0, 0, 0, 0, 0, 32'h7fffffff);
      send_fields(OP_TANGENT, 0, 0, 5 * one, 3 * one, 4 * one, 0);
      send_fields(OP_TANGENT, 0, 0, 5 * one, one, one, 0);
      send_fields(OP_TANGENT, 0, 0, 5 * one, 10 * one, 0, 0);
      send_fields(OP_TANGENT, one, -one, 2 * one, -7 * one, 3 * one, 0);
      send_fields(OP_TANGENT, 32'sh80000000, 32'sh80000000, 32'h7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 0);
      send_fields(OP_TANGENT, 32'sh7fffffff, 32'sh7fffffff, 32'h40000000,
                  32'sh80000000, 32'sh7fffffff, 32'h7fffffff);
      send_fields(OP_TANGENT, 0, 0, 0, 1, 0, 0);
      send_fields(OP_TANGENT, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff,
                  32'sh80000000, 0);
   endtask

   task automatic test_random_intersect(input int count);
      for (int i = 0; i < count; i++) send_shape(random_shape(OP_INTERSECT));
   endtask

   task automatic test_random_tangent(input int count);
      for (int i = 0; i < count; i++) send_shape(random_shape(OP_TANGENT));
   endtask

   task automatic test_mixed(input int count);
      for (int i = 0; i < count; i++) send_shape(random_shape(logic'($urandom_range(0, 1))));
   endtask

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 12);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      points_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            $error("unexpected response transaction");
            fails++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_bus.found !== e.found) begin
               $error("found: expected %0d, actual %0d", e.found, rsp_bus.found);
               fails++;
            end
            if (rsp_bus.point_a_x !== e.ax) begin
               $error("point_a_x: expected %0d, actual %0d", e.ax, rsp_bus.point_a_x);
               fails++;
            end
            if (rsp_bus.point_a_y !== e.ay) begin
               $error("point_a_y: expected %0d, actual %0d", e.ay, rsp_bus.point_a_y);
               fails++;
            end
            if (rsp_bus.point_b_x !== e.bx) begin
               $error("point_b_x: expected %0d, actual %0d", e.bx, rsp_bus.point_b_x);
               fails++;
            end
            if (rsp_bus.point_b_y !== e.by) begin
               $error("point_b_y: expected %0d, actual %0d", e.by, rsp_bus.point_b_y);
               fails++;
            end
         end
      end
   end

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.opcode          = OP_INTERSECT;
      req_bus.first_center_x  = '0;
      req_bus.first_center_y  = '0;
      req_bus.first_radius    = '0;
      req_bus.second_center_x = '0;
      req_bus.second_center_y = '0;
      req_bus.second_radius   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_intersect(700);
      wait_drained();
      test_random_tangent(600);
      test_mixed(300);
      calm = 1'b1;
      test_mixed(230);

      wait_drained();
      repeat (200) @(posedge clock);
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
hdl/cit_pkg.sv
hdl/cit_if.sv
hdl/cit_div.sv
hdl/circle_intersection_and_tangent.sv
bench/circle_intersection_and_tangent_tb.sv
